// ----- rtl/pllnd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pllnd_pkg;

    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_ZERO = 2'd1;
    localparam status_t STATUS_SAT  = 2'd2;

    typedef logic [1:0] div_sel_t;

    localparam div_sel_t DIV_GCD = 2'd0;
    localparam div_sel_t DIV_R   = 2'd1;
    localparam div_sel_t DIV_N   = 2'd2;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     capture;
        div_sel_t div_sel;
        logic     take_sum;
        logic     clear;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/pllnd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pllnd_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  pllnd_pkg::sts_t  sts,
    output pllnd_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_GCD_WAIT = 3'd2;
    localparam logic [2:0] S_R_START  = 3'd3;
    localparam logic [2:0] S_R_WAIT   = 3'd4;
    localparam logic [2:0] S_N_START  = 3'd5;
    localparam logic [2:0] S_N_WAIT   = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = pllnd_pkg::DIV_GCD;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.a_zero && sts.b_zero) begin
                    cmd.clear  = 1'b1;
                    state_next = S_FINISH;
                end else if (sts.a_zero || sts.b_zero) begin
                    cmd.take_sum = 1'b1;
                    state_next   = S_R_START;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_R_START: begin
                cmd.div_sel   = pllnd_pkg::DIV_R;
                cmd.div_start = 1'b1;
                state_next    = S_R_WAIT;
            end
            S_R_WAIT: begin
                cmd.div_sel = pllnd_pkg::DIV_R;
                if (!sts.div_busy) begin
                    cmd.capture = 1'b1;
                    state_next  = S_N_START;
                end
            end
            S_N_START: begin
                cmd.div_sel   = pllnd_pkg::DIV_N;
                cmd.div_start = 1'b1;
                state_next    = S_N_WAIT;
            end
            S_N_WAIT: begin
                cmd.div_sel = pllnd_pkg::DIV_N;
                if (!sts.div_busy) begin
                    cmd.capture = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pllnd_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pllnd_dp #(
    parameter int FREQ_WIDTH = 30,
    parameter int R_WIDTH    = 14,
    parameter int N_WIDTH    = 13
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  pllnd_pkg::cmd_t              cmd,
    output pllnd_pkg::sts_t              sts,
    input  wire [FREQ_WIDTH-1:0]         in_fref,
    input  wire [FREQ_WIDTH-1:0]         in_fvco,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [R_WIDTH-1:0]           out_r,
    output logic [N_WIDTH-1:0]           out_n,
    output logic [FREQ_WIDTH-1:0]        out_fcomp,
    output pllnd_pkg::status_t           out_status
);

    localparam int W     = FREQ_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam int RX_W  = W + R_WIDTH;
    localparam int NX_W  = W + N_WIDTH;

    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     fref_reg, fref_next;
    logic [W-1:0]     fvco_reg, fvco_next;
    logic [W-1:0]     fcomp_reg, fcomp_next;
    logic [W-1:0]     rq_reg, rq_next;
    logic [W-1:0]     nq_reg, nq_next;
    logic             zero_reg, zero_next;
    logic             a_larger_reg, a_larger_next;

    // shared restoring divider, one quotient bit per cycle
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;
    logic             a_ge_b;

    logic [R_WIDTH-1:0]       or_reg, or_next;
    logic [N_WIDTH-1:0]       on_reg, on_next;
    logic [W-1:0]             of_reg, of_next;
    pllnd_pkg::status_t       os_reg, os_next;
    logic                     ov_reg, ov_next;

    logic [RX_W-1:0]  rq_ext;
    logic [NX_W-1:0]  nq_ext;
    logic             r_ovf;
    logic             n_ovf;

    assign a_ge_b  = (a_reg >= b_reg);
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    assign rq_ext = RX_W'(rq_reg);
    assign nq_ext = NX_W'(nq_reg);
    assign r_ovf  = (rq_ext > RX_W'({R_WIDTH{1'b1}}));
    assign n_ovf  = (nq_ext > NX_W'({N_WIDTH{1'b1}}));

    assign sts.a_zero   = (a_reg == '0);
    assign sts.b_zero   = (b_reg == '0);
    assign sts.div_busy = busy_reg;
    assign sts.out_free = !ov_reg || out_ready;

    always_comb begin
        a_next        = a_reg;
        b_next        = b_reg;
        fref_next     = fref_reg;
        fvco_next     = fvco_reg;
        fcomp_next    = fcomp_reg;
        rq_next       = rq_reg;
        nq_next       = nq_reg;
        zero_next     = zero_reg;
        a_larger_next = a_larger_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;

        if (cmd.load) begin
            a_next    = in_fref;
            b_next    = in_fvco;
            fref_next = in_fref;
            fvco_next = in_fvco;
            zero_next = 1'b0;
        end

        if (cmd.clear) begin
            zero_next  = 1'b1;
            fcomp_next = '0;
        end

        if (cmd.take_sum) begin
            fcomp_next = a_reg | b_reg;
        end

        if (busy_reg) begin
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
            end
        end

        if (cmd.div_start) begin
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            case (cmd.div_sel)
                pllnd_pkg::DIV_GCD: begin
                    a_larger_next = a_ge_b;
                    quo_next      = a_ge_b ? a_reg : b_reg;
                    dvs_next      = a_ge_b ? b_reg : a_reg;
                end
                pllnd_pkg::DIV_R: begin
                    quo_next = fref_reg;
                    dvs_next = fcomp_reg;
                end
                pllnd_pkg::DIV_N: begin
                    quo_next = fvco_reg;
                    dvs_next = fcomp_reg;
                end
                default: begin
                    quo_next = '0;
                    dvs_next = fcomp_reg;
                end
            endcase
        end

        if (cmd.capture) begin
            case (cmd.div_sel)
                pllnd_pkg::DIV_GCD: begin
                    if (a_larger_reg) begin
                        a_next = rem_reg;
                    end else begin
                        b_next = rem_reg;
                    end
                end
                pllnd_pkg::DIV_R: begin
                    rq_next = quo_reg;
                end
                pllnd_pkg::DIV_N: begin
                    nq_next = quo_reg;
                end
                default: begin
                    rq_next = rq_reg;
                end
            endcase
        end
    end

    always_comb begin
        or_next = or_reg;
        on_next = on_reg;
        of_next = of_reg;
        os_next = os_reg;
        ov_next = ov_reg;
        if (out_ready) begin
            ov_next = 1'b0;
        end
        if (cmd.out_load) begin
            ov_next = 1'b1;
            if (zero_reg) begin
                or_next = '0;
                on_next = '0;
                of_next = '0;
                os_next = pllnd_pkg::STATUS_ZERO;
            end else begin
                or_next = r_ovf ? {R_WIDTH{1'b1}} : rq_ext[R_WIDTH-1:0];
                on_next = n_ovf ? {N_WIDTH{1'b1}} : nq_ext[N_WIDTH-1:0];
                of_next = fcomp_reg;
                os_next = (r_ovf || n_ovf) ? pllnd_pkg::STATUS_SAT : pllnd_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        fref_reg     <= fref_next;
        fvco_reg     <= fvco_next;
        fcomp_reg    <= fcomp_next;
        rq_reg       <= rq_next;
        nq_reg       <= nq_next;
        zero_reg     <= zero_next;
        a_larger_reg <= a_larger_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        cnt_reg      <= cnt_next;
        or_reg       <= or_next;
        on_reg       <= on_next;
        of_reg       <= of_next;
        os_reg       <= os_next;
    end

    assign out_valid  = ov_reg;
    assign out_r      = or_reg;
    assign out_n      = on_reg;
    assign out_fcomp  = of_reg;
    assign out_status = os_reg;

endmodule

`default_nettype wire

// ----- rtl/pll_ref_n_divider_calc.sv -----
// An accepted item runs k remainder steps, then the R and N divisions, and then its result is loaded,
// where k is the number of Euclid remainder steps (0 to 42 at 30 bits); if both inputs are 0, no division runs.
// The final load waits on an unread result.
// Each remainder and each of the two final divisions runs on one shared bit-serial divider.
// One item is in work at a time; the next is accepted while a finished result still waits.
// Reset (aresetn low, synchronous) returns the controller to idle and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module pll_ref_n_divider_calc #(
    parameter int FREQ_WIDTH = 30,
    parameter int R_WIDTH    = 14,
    parameter int N_WIDTH    = 13
) (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        s_tvalid,
    output logic                                       s_tready,
    // fref_hz, fvco_hz
    input  wire  [((2*FREQ_WIDTH+7)/8)*8-1:0]          s_tdata,
    output logic                                       m_tvalid,
    input  wire                                        m_tready,
    // r_count, n_count, fcomp_hz, status
    output logic [((R_WIDTH+N_WIDTH+FREQ_WIDTH+pllnd_pkg::STATUS_W+7)/8)*8-1:0] m_tdata
);

    localparam int M_TDATA_W = ((R_WIDTH + N_WIDTH + FREQ_WIDTH + pllnd_pkg::STATUS_W + 7) / 8) * 8;

    pllnd_pkg::cmd_t     cmd;
    pllnd_pkg::sts_t     sts;
    logic [R_WIDTH-1:0]    out_r;
    logic [N_WIDTH-1:0]    out_n;
    logic [FREQ_WIDTH-1:0] out_fcomp;
    pllnd_pkg::status_t    out_status;

    pllnd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pllnd_dp #(
        .FREQ_WIDTH (FREQ_WIDTH),
        .R_WIDTH    (R_WIDTH),
        .N_WIDTH    (N_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_fref    (s_tdata[FREQ_WIDTH-1:0]),
        .in_fvco    (s_tdata[2*FREQ_WIDTH-1:FREQ_WIDTH]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_r      (out_r),
        .out_n      (out_n),
        .out_fcomp  (out_fcomp),
        .out_status (out_status)
    );

    assign m_tdata = M_TDATA_W'({out_status, out_fcomp, out_n, out_r});

endmodule

`default_nettype wire

// ----- rtl/pllnd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pllnd_checker #(
    parameter int FREQ_WIDTH = 30,
    parameter int R_WIDTH    = 14,
    parameter int N_WIDTH    = 13
) (
    input wire                                        aclk,
    input wire                                        aresetn,
    input wire                                        s_tvalid,
    input wire                                        s_tready,
    input wire                                        m_tvalid,
    input wire                                        m_tready,
    input wire [((R_WIDTH+N_WIDTH+FREQ_WIDTH+pllnd_pkg::STATUS_W+7)/8)*8-1:0] m_tdata
);

    localparam int F_LO = R_WIDTH + N_WIDTH;
    localparam int S_LO = F_LO + FREQ_WIDTH;

    logic [R_WIDTH-1:0]    r_f;
    logic [N_WIDTH-1:0]    n_f;
    logic [FREQ_WIDTH-1:0] f_f;
    pllnd_pkg::status_t    st_f;

    assign r_f  = m_tdata[R_WIDTH-1:0];
    assign n_f  = m_tdata[F_LO-1:R_WIDTH];
    assign f_f  = m_tdata[S_LO-1:F_LO];
    assign st_f = m_tdata[S_LO+pllnd_pkg::STATUS_W-1:S_LO];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_f == pllnd_pkg::STATUS_ZERO |-> r_f == '0 && n_f == '0 && f_f == '0)
        else $error("zero status with nonzero fields");

    a_fcomp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st_f == pllnd_pkg::STATUS_OK || st_f == pllnd_pkg::STATUS_SAT)
        |-> f_f != '0 && (r_f != '0 || n_f != '0))
        else $error("divider result inconsistent with status");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

endmodule

bind pll_ref_n_divider_calc pllnd_checker #(
    .FREQ_WIDTH (FREQ_WIDTH),
    .R_WIDTH    (R_WIDTH),
    .N_WIDTH    (N_WIDTH)
) u_pllnd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int FREQ_W = 30;
    localparam int R_W    = 14;
    localparam int N_W    = 13;

    localparam logic [FREQ_W-1:0] F_MAX = '1;
    localparam int unsigned R_MAX = (1 << R_W) - 1;
    localparam int unsigned N_MAX = (1 << N_W) - 1;

    typedef struct {
        logic [R_W-1:0]       r_count;
        logic [N_W-1:0]       n_count;
        logic [FREQ_W-1:0]    fcomp_hz;
        pllnd_pkg::status_t   status;
    } div_result_t;

    // typed = 1: expected fields below are taken as written, else predicted
    typedef struct packed {
        logic                 typed;
        logic [FREQ_W-1:0]    fref;
        logic [FREQ_W-1:0]    fvco;
        logic [R_W-1:0]       r_count;
        logic [N_W-1:0]       n_count;
        logic [FREQ_W-1:0]    fcomp_hz;
        pllnd_pkg::status_t   status;
    } stim_row_t;

    localparam int N_ROWS = 20;

    stim_row_t stim_table [0:N_ROWS-1] = '{
        '{1'b1, 30'd0,        30'd0,        14'd0,     13'd0,    30'd0,    pllnd_pkg::STATUS_ZERO},
        '{1'b1, 30'd0,        30'd1000,     14'd0,     13'd1,    30'd1000, pllnd_pkg::STATUS_OK},
        '{1'b1, 30'd1000,     30'd0,        14'd1,     13'd0,    30'd1000, pllnd_pkg::STATUS_OK},
        '{1'b1, 30'd0,        F_MAX,        14'd0,     13'd1,    F_MAX,    pllnd_pkg::STATUS_OK},
        '{1'b1, F_MAX,        30'd0,        14'd1,     13'd0,    F_MAX,    pllnd_pkg::STATUS_OK},
        '{1'b1, 30'd1,        30'd1,        14'd1,     13'd1,    30'd1,    pllnd_pkg::STATUS_OK},
        '{1'b1, F_MAX,        F_MAX,        14'd1,     13'd1,    F_MAX,    pllnd_pkg::STATUS_OK},
        '{1'b1, 30'd1,        F_MAX,        14'd1,     13'd8191, 30'd1,    pllnd_pkg::STATUS_SAT},
        '{1'b1, F_MAX,        30'd1,        14'd16383, 13'd1,    30'd1,    pllnd_pkg::STATUS_SAT},
        '{1'b1, 30'd16383,    30'd8191,     14'd16383, 13'd8191, 30'd1,    pllnd_pkg::STATUS_OK},
        '{1'b1, 30'd16384,    30'd8191,     14'd16383, 13'd8191, 30'd1,    pllnd_pkg::STATUS_SAT},
        '{1'b1, 30'd16383,    30'd8192,     14'd16383, 13'd8191, 30'd1,    pllnd_pkg::STATUS_SAT},
        // consecutive Fibonacci numbers: longest remainder chain
        '{1'b1, 30'd701408733, 30'd433494437, 14'd16383, 13'd8191, 30'd1, pllnd_pkg::STATUS_SAT},
        '{1'b1, 30'd1000,     30'd1000,     14'd1,     13'd1,    30'd1000, pllnd_pkg::STATUS_OK},
        '{1'b0, 30'd10000000, 30'd1000000000, 14'd0,   13'd0,    30'd0,    pllnd_pkg::STATUS_OK},
        '{1'b0, 30'd26000000, 30'd868000000, 14'd0,    13'd0,    30'd0,    pllnd_pkg::STATUS_OK},
        '{1'b0, 30'd19200000, 30'd2450000,  14'd0,     13'd0,    30'd0,    pllnd_pkg::STATUS_OK},
        '{1'b0, 30'd123456789, 30'd987654321, 14'd0,   13'd0,    30'd0,    pllnd_pkg::STATUS_OK},
        '{1'b0, 30'h2AAAAAAA, 30'h15555555, 14'd0,     13'd0,    30'd0,    pllnd_pkg::STATUS_OK},
        '{1'b0, 30'h15555555, 30'h2AAAAAAA, 14'd0,     13'd0,    30'd0,    pllnd_pkg::STATUS_OK}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    div_result_t pending_dividers [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int n_results      = 0;
    int n_ok           = 0;
    int n_sat          = 0;
    int n_zero         = 0;

    pll_ref_n_divider_calc #(
        .FREQ_WIDTH(FREQ_W),
        .R_WIDTH   (R_W),
        .N_WIDTH   (N_W)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic div_result_t calc_dividers(input logic [FREQ_W-1:0] fref,
                                                  input logic [FREQ_W-1:0] fvco);
        logic [FREQ_W-1:0] a;
        logic [FREQ_W-1:0] b;
        logic [FREQ_W-1:0] g;
        logic [FREQ_W-1:0] quo_r;
        logic [FREQ_W-1:0] quo_n;
        div_result_t res;
        a = fref;
        b = fvco;
        res.r_count  = '0;
        res.n_count  = '0;
        res.fcomp_hz = '0;
        res.status   = pllnd_pkg::STATUS_OK;
        if (a == 0 && b == 0) begin
            res.status = pllnd_pkg::STATUS_ZERO;
        end else begin
            while (a != 0 && b != 0) begin
                if (a >= b) a = a % b;
                else b = b % a;
            end
            g = a + b;
            quo_r = fref / g;
            quo_n = fvco / g;
            res.fcomp_hz = g;
            if (quo_r > R_MAX) begin
                res.r_count = '1;
                res.status  = pllnd_pkg::STATUS_SAT;
            end else begin
                res.r_count = quo_r[R_W-1:0];
            end
            if (quo_n > N_MAX) begin
                res.n_count = '1;
                res.status  = pllnd_pkg::STATUS_SAT;
            end else begin
                res.n_count = quo_n[N_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic issue_request(input logic [FREQ_W-1:0] fref, input logic [FREQ_W-1:0] fvco,
                                 input div_result_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, fvco, fref};
        do @(posedge aclk); while (!s_tready);
        pending_dividers.push_back(want);
    endtask

    task automatic pick_request(output logic [FREQ_W-1:0] fref, output logic [FREQ_W-1:0] fvco);
        int unsigned kind;
        logic [63:0] r;
        logic [63:0] n;
        logic [63:0] g;
        logic [63:0] lim;
        kind = $urandom_range(99);
        fref = '0;
        fvco = '0;
        if (kind < 60) begin
            // divider pair (r may exceed R_MAX) scaled by a common factor g
            r   = $urandom_range(1, 18000);
            n   = $urandom_range(1, 9000);
            lim = F_MAX / ((r > n) ? r : n);
            g   = $urandom_range(1, 32'(lim));
            fref = FREQ_W'(r * g);
            fvco = FREQ_W'(n * g);
        end else if (kind < 75) begin
            fref = FREQ_W'(100000 * $urandom_range(1, 1000));
            fvco = FREQ_W'(1000 * $urandom_range(1, 1000000));
        end else if (kind < 90) begin
            fref = FREQ_W'($urandom);
            fvco = FREQ_W'($urandom);
        end else if (kind < 95) begin
            if ($urandom_range(1)) fref = FREQ_W'($urandom);
            else fvco = FREQ_W'($urandom);
        end else if (kind < 97) begin
            fref = '0;
        end else begin
            fref = FREQ_W'($urandom_range(63));
            fvco = FREQ_W'($urandom_range(63));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_dividers.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        div_result_t want;
        if (m_tvalid && m_tready) begin
            if (pending_dividers.size() == 0) begin
                $error("result item with nothing outstanding, tdata=%h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_dividers.pop_front();
                n_results++;
                if (want.status == pllnd_pkg::STATUS_OK) n_ok++;
                else if (want.status == pllnd_pkg::STATUS_SAT) n_sat++;
                else n_zero++;
                if (m_tdata[13:0] !== want.r_count) begin
                    $error("r_count: expected %0d, got %0d", want.r_count, m_tdata[13:0]);
                    mismatch_count++;
                end
                if (m_tdata[26:14] !== want.n_count) begin
                    $error("n_count: expected %0d, got %0d", want.n_count, m_tdata[26:14]);
                    mismatch_count++;
                end
                if (m_tdata[56:27] !== want.fcomp_hz) begin
                    $error("fcomp_hz: expected %0d, got %0d", want.fcomp_hz, m_tdata[56:27]);
                    mismatch_count++;
                end
                if (m_tdata[58:57] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[58:57]);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin : stimulus
        logic [FREQ_W-1:0] fref;
        logic [FREQ_W-1:0] fvco;
        div_result_t want;
        int phase;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (stim_table[i].typed) begin
                want.r_count  = stim_table[i].r_count;
                want.n_count  = stim_table[i].n_count;
                want.fcomp_hz = stim_table[i].fcomp_hz;
                want.status   = stim_table[i].status;
            end else begin
                want = calc_dividers(stim_table[i].fref, stim_table[i].fvco);
            end
            issue_request(stim_table[i].fref, stim_table[i].fvco, want);
        end
        // hold off until the block has delivered everything
        drain_results();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
                default: begin src_idle_pct = 19; sink_stall_pct = 19; end
            endcase
            for (int k = 0; k < 258; k++) begin
                pick_request(fref, fvco);
                issue_request(fref, fvco, calc_dividers(fref, fvco));
            end
            if (phase == 1) drain_results();
        end

        drain_results();
        repeat (1600) @(posedge aclk);

        $display("Checked %0d divider results: %0d in range, %0d saturated, %0d both-zero.",
                 n_results, n_ok, n_sat, n_zero);
        $display("Stimulus: directed extremes, lock-ratio pairs, raw 30-bit and zero inputs.");
        if (mismatch_count == 0) $display("pll_ref_n_divider_calc test passed");
        else $display("pll_ref_n_divider_calc test failed");
        $finish;
    end

    initial begin : watchdog
        #30000000;
        $display("pll_ref_n_divider_calc test failed");
        $finish;
    end

endmodule

// ----- pll_ref_n_divider_calc.f -----
rtl/pllnd_pkg.sv
rtl/pllnd_ctrl.sv
rtl/pllnd_dp.sv
rtl/pll_ref_n_divider_calc.sv
rtl/pllnd_checker.sv
tb/sv/tb.sv
